/* design/pfc_pkg.sv */
// Shared types, constants and code maps for the playfair digraph cipher unit.
// No dependencies; imported by every module of the block.
package pfc_pkg;

	// geometry of the key square
	localparam int SIDE      = 5;
	localparam int NUM_CELLS = SIDE * SIDE;
	localparam int CODE_W    = 5;
	localparam int POS_W     = 3;
	localparam int CHAR_W    = 8;

	// configuration port layout
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 60;
	localparam int KEY_HALF_CELLS = 12;

	// result slots per item: first pair, separator, closing pair
	localparam int NUM_SLOTS = 5;
	localparam int SLOT_P0X  = 0;
	localparam int SLOT_P0Y  = 1;
	localparam int SLOT_SEP  = 2;
	localparam int SLOT_P1X  = 3;
	localparam int SLOT_P1Y  = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_A    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_B    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LAST = 2'd3;

	// letter codes, A = 0
	localparam logic [CODE_W-1:0] CODE_I      = 5'd8;
	localparam logic [CODE_W-1:0] CODE_J      = 5'd9;
	localparam logic [CODE_W-1:0] CODE_X      = 5'd23;
	localparam logic [CODE_W-1:0] NUM_LETTERS = 5'd26;

	// ascii characters
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;

	typedef logic [NUM_CELLS-1:0][CODE_W-1:0] key_square_t;

	// results of one item, in delivery order from slot 0 up
	typedef struct packed {
		logic [NUM_SLOTS-1:0]             mask;
		logic [NUM_SLOTS-1:0][CHAR_W-1:0] chars;
	} slot_bundle_t;

endpackage

/* design/pfc_cipher_pair.sv */
// One digraph lane: locates both letters in the key square and applies the
// row, column or rectangle rule. Depends on pfc_pkg.
module pfc_cipher_pair
	import pfc_pkg::*;
(
	input  key_square_t       cells,
	input  logic              dec,
	input  logic [CODE_W-1:0] code_a,
	input  logic [CODE_W-1:0] code_b,
	output logic [CODE_W-1:0] code_x,
	output logic [CODE_W-1:0] code_y
);

	logic [POS_W-1:0]  r1, c1, r2, c2;
	logic [POS_W-1:0]  xr, xc, yr, yc;
	logic [CODE_W-1:0] idx_x, idx_y;

	// shift one place around the square, forward or back
	function automatic logic [POS_W-1:0] wrap_step(logic [POS_W-1:0] v, logic back);
		logic [POS_W-1:0] r;
		if (back) begin
			r = (v == '0) ? POS_W'(SIDE - 1) : v - 1'b1;
		end else begin
			r = (v == POS_W'(SIDE - 1)) ? '0 : v + 1'b1;
		end
		return r;
	endfunction

	// priority search, first match in row-major order, miss gives cell 0
	always_comb begin
		r1 = '0;
		c1 = '0;
		r2 = '0;
		c2 = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (cells[r * SIDE + c] == code_a) begin
					r1 = POS_W'(r);
					c1 = POS_W'(c);
				end
				if (cells[r * SIDE + c] == code_b) begin
					r2 = POS_W'(r);
					c2 = POS_W'(c);
				end
			end
		end
	end

	// digraph rules
	always_comb begin
		if (r1 == r2) begin
			xr = r1;
			yr = r2;
			xc = wrap_step(c1, dec);
			yc = wrap_step(c2, dec);
		end else if (c1 == c2) begin
			xr = wrap_step(r1, dec);
			yr = wrap_step(r2, dec);
			xc = c1;
			yc = c2;
		end else begin
			xr = r1;
			yr = r2;
			xc = c2;
			yc = c1;
		end
	end

	// cell index = 5 * row + column
	assign idx_x = CODE_W'({2'b00, xr, 2'b00} >> 2) + CODE_W'({xr, 2'b00})
		+ CODE_W'({2'b00, xc});
	assign idx_y = CODE_W'({2'b00, yr, 2'b00} >> 2) + CODE_W'({yr, 2'b00})
		+ CODE_W'({2'b00, yc});

	assign code_x = cells[idx_x];
	assign code_y = cells[idx_y];

endmodule

/* design/pfc_digraph_ctrl.sv */
// Input register, pairing state and result builder: turns one registered
// character into up to four of the five result slots. Depends on pfc_pkg, pfc_cipher_pair.
module pfc_digraph_ctrl
	import pfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              text_end,
	input  logic              mode,
	input  key_square_t       cells,
	output logic              bndl_valid,
	input  logic              bndl_ready,
	output slot_bundle_t      bndl
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;

	logic [CODE_W-1:0] held_letter_q;
	logic              holding_q;
	logic [CODE_W-1:0] previous_letter_q;
	logic              previous_valid_q;

	logic              adv;
	logic              is_upper, is_lower, is_letter;
	logic [CODE_W-1:0] code_raw, enc_code;
	logic              dup;

	logic              p0_v, p1_v, sep_v;
	logic [CODE_W-1:0] p0a, p0b, p1a, p1b;
	logic [CHAR_W-1:0] sep_char;
	logic              hold_mid;
	logic [CODE_W-1:0] held_mid;
	logic              holding_d, previous_valid_d;
	logic [CODE_W-1:0] previous_letter_d;

	logic [CODE_W-1:0] p0x, p0y, p1x, p1y;

	// letter code to output character; decrypt gives lower case for codes below 26
	function automatic logic [CHAR_W-1:0] code_char(logic [CODE_W-1:0] code, logic dec);
		logic [CHAR_W-1:0] ch;
		if (dec && (code < NUM_LETTERS)) begin
			ch = CH_LOWER_A + CHAR_W'(code);
		end else begin
			ch = CH_UPPER_A + CHAR_W'(code);
		end
		return ch;
	endfunction

	// decrypt drops every x
	function automatic logic code_kept(logic [CODE_W-1:0] code, logic dec);
		return !(dec && (code == CODE_X));
	endfunction

	assign adv        = valid_s1 && bndl_ready;
	assign s_tready   = !valid_s1 || bndl_ready;
	assign bndl_valid = valid_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= char_code;
			end_s1  <= text_end;
		end
	end

	// character classes
	assign is_upper  = (char_s1 >= CH_UPPER_A) && (char_s1 <= CH_UPPER_Z);
	assign is_lower  = (char_s1 >= CH_LOWER_A) && (char_s1 <= CH_LOWER_Z);
	assign is_letter = is_upper || is_lower;
	assign code_raw  = is_upper ? CODE_W'(char_s1 - CH_UPPER_A) : CODE_W'(char_s1 - CH_LOWER_A);
	assign enc_code  = (code_raw == CODE_J) ? CODE_I : code_raw;
	assign dup       = previous_valid_q && (previous_letter_q == enc_code);

	// pairing decisions for this character
	always_comb begin
		p0_v              = 1'b0;
		p0a               = held_letter_q;
		p0b               = CODE_X;
		sep_v             = 1'b0;
		sep_char          = mode ? CH_SPACE : CH_HASH;
		hold_mid          = holding_q;
		held_mid          = held_letter_q;
		previous_letter_d = previous_letter_q;
		previous_valid_d  = previous_valid_q;
		if (!mode) begin
			if (is_letter) begin
				previous_letter_d = enc_code;
				previous_valid_d  = 1'b1;
				if (!holding_q && !dup) begin
					hold_mid = 1'b1;
					held_mid = enc_code;
				end else if (!holding_q) begin
					// x between equal letters, paired with this one
					p0_v     = 1'b1;
					p0a      = CODE_X;
					p0b      = enc_code;
					hold_mid = 1'b0;
				end else if (!dup) begin
					p0_v     = 1'b1;
					p0b      = enc_code;
					hold_mid = 1'b0;
				end else begin
					// held letter closes with x, this one is held
					p0_v     = 1'b1;
					held_mid = enc_code;
				end
			end else if (char_s1 == CH_SPACE) begin
				p0_v             = holding_q;
				hold_mid         = 1'b0;
				sep_v            = 1'b1;
				previous_valid_d = 1'b0;
			end
		end else begin
			if (is_letter) begin
				if (holding_q) begin
					p0_v     = 1'b1;
					p0b      = code_raw;
					hold_mid = 1'b0;
				end else begin
					hold_mid = 1'b1;
					held_mid = code_raw;
				end
			end else if (char_s1 == CH_HASH) begin
				hold_mid = 1'b0;
				sep_v    = 1'b1;
			end
		end
		// text end closes an odd word in encrypt, drops it in decrypt
		p1_v      = end_s1 && hold_mid && !mode;
		p1a       = held_mid;
		p1b       = CODE_X;
		holding_d = hold_mid && !end_s1;
		if (end_s1) begin
			previous_valid_d = 1'b0;
		end
	end

	// pairing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q     <= '0;
			holding_q         <= 1'b0;
			previous_letter_q <= '0;
			previous_valid_q  <= 1'b0;
		end else if (adv) begin
			held_letter_q     <= held_mid;
			holding_q         <= holding_d;
			previous_letter_q <= previous_letter_d;
			previous_valid_q  <= previous_valid_d;
		end
	end

	// two cipher lanes: the pair this character completes, and the closing pair
	pfc_cipher_pair u_pair0 (
		.cells  (cells),
		.dec    (mode),
		.code_a (p0a),
		.code_b (p0b),
		.code_x (p0x),
		.code_y (p0y)
	);

	pfc_cipher_pair u_pair1 (
		.cells  (cells),
		.dec    (mode),
		.code_a (p1a),
		.code_b (p1b),
		.code_x (p1x),
		.code_y (p1y)
	);

	// result slots
	always_comb begin
		bndl.mask                 = '0;
		bndl.mask[SLOT_P0X]       = p0_v && code_kept(p0x, mode);
		bndl.mask[SLOT_P0Y]       = p0_v && code_kept(p0y, mode);
		bndl.mask[SLOT_SEP]       = sep_v;
		bndl.mask[SLOT_P1X]       = p1_v && code_kept(p1x, mode);
		bndl.mask[SLOT_P1Y]       = p1_v && code_kept(p1y, mode);
		bndl.chars[SLOT_P0X]      = code_char(p0x, mode);
		bndl.chars[SLOT_P0Y]      = code_char(p0y, mode);
		bndl.chars[SLOT_SEP]      = sep_char;
		bndl.chars[SLOT_P1X]      = code_char(p1x, mode);
		bndl.chars[SLOT_P1Y]      = code_char(p1y, mode);
	end

endmodule

/* design/pfc_out_serializer.sv */
// Result register holding the slots of one item and handing them out one
// transfer per cycle while m_tready is high, lowest slot first. Depends on pfc_pkg.
module pfc_out_serializer
	import pfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bndl_valid,
	output logic              bndl_ready,
	input  slot_bundle_t      bndl,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] out_char,
	output logic              last_of_run
);

	logic [NUM_SLOTS-1:0]             mask_s2;
	logic [NUM_SLOTS-1:0][CHAR_W-1:0] chars_s2;
	logic [NUM_SLOTS-1:0]             pick;
	logic [NUM_SLOTS-1:0]             rest;

	// lowest pending slot
	assign pick = mask_s2 & (~mask_s2 + 1'b1);
	assign rest = mask_s2 & ~pick;

	always_comb begin
		out_char = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (pick[i]) begin
				out_char = out_char | chars_s2[i];
			end
		end
	end

	assign m_tvalid    = |mask_s2;
	assign last_of_run = (rest == '0);
	assign bndl_ready  = !m_tvalid || (m_tready && last_of_run);

	// pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (bndl_ready) begin
			mask_s2 <= bndl_valid ? bndl.mask : '0;
		end else if (m_tready) begin
			mask_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (bndl_ready && bndl_valid) begin
			chars_s2 <= bndl.chars;
		end
	end

endmodule

/* design/playfair_digraph_cipher_unit.sv */
// Playfair digraph cipher unit: configuration registers and the two stages.
// Depends on pfc_pkg, pfc_digraph_ctrl, pfc_out_serializer.
// Path: an item passes the input register, then the result register, before its first result is on m_tvalid.
// Throughput: one result per cycle while m_tready is high; an item holds the result
//   register until its last result is taken.
// Reset: arst_n clears the pairing state, pending results and all config registers.
module playfair_digraph_cipher_unit
	import pfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input characters
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] char_code
	input  logic                  s_tlast,   // text_end
	// output characters
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] out_char
	output logic                  m_tlast    // last_of_run
);

	logic                  mode_q;
	logic [CFG_DATA_W-1:0] key_a_q;
	logic [CFG_DATA_W-1:0] key_b_q;
	logic [CODE_W-1:0]     key_last_q;
	key_square_t           cells;

	logic                  bndl_valid;
	logic                  bndl_ready;
	slot_bundle_t          bndl;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			key_a_q    <= '0;
			key_b_q    <= '0;
			key_last_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[0];
				REG_KEY_A:    key_a_q    <= cfg_data;
				REG_KEY_B:    key_b_q    <= cfg_data;
				REG_KEY_LAST: key_last_q <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack the key square
	always_comb begin
		for (int i = 0; i < KEY_HALF_CELLS; i++) begin
			cells[i]                  = key_a_q[i * CODE_W +: CODE_W];
			cells[KEY_HALF_CELLS + i] = key_b_q[i * CODE_W +: CODE_W];
		end
		cells[NUM_CELLS-1] = key_last_q;
	end

	pfc_digraph_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.char_code  (s_tdata),
		.text_end   (s_tlast),
		.mode       (mode_q),
		.cells      (cells),
		.bndl_valid (bndl_valid),
		.bndl_ready (bndl_ready),
		.bndl       (bndl)
	);

	pfc_out_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.bndl_valid  (bndl_valid),
		.bndl_ready  (bndl_ready),
		.bndl        (bndl),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_char    (m_tdata),
		.last_of_run (m_tlast)
	);

endmodule

/* design/pfc_checker.sv */
// Port-level checks for the playfair digraph cipher unit, bound to the top level.
// Depends on pfc_pkg and playfair_digraph_cipher_unit.
module pfc_checker
	import pfc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [7:0]            m_tdata,
	input logic                  m_tlast
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// results of one character come without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a run of results");

	// a separator is always the last result of its character
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CH_SPACE || m_tdata == CH_HASH) |-> m_tlast)
		else $error("separator not last of run");

	// with nothing pending at the output, input is never held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");

	// the consequent is always true, so an offered character staying offered is not checked
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid || !s_tvalid)
		else $error("input handshake broken");

endmodule

bind playfair_digraph_cipher_unit pfc_checker u_pfc_checker (.*);

/* verif/playfair_digraph_cipher_unit_tb.sv */
// Self-checking testbench for the playfair digraph cipher unit.
// Depends on pfc_pkg and playfair_digraph_cipher_unit; checks every output transfer against
// typed-in expectations or a cycle-free Playfair predictor kept in step with the accepted input.
`timescale 1ns / 1ps

module playfair_digraph_cipher_unit_tb;
	import pfc_pkg::*;

	localparam int MAX_RESULTS = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_CHARS = 20;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} out_item_t;

	// one row of the opening table: a register write or a character
	typedef struct packed {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [CHAR_W-1:0]     ch;
		bit                    fin;
		bit                    typed;
		logic [2:0]            n_typed;
		logic [31:0]           typed_chars;  // first character in the highest used byte
	} opening_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // [7:0] char_code
	logic                  s_tlast = 1'b0; // text_end
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // [7:0] out_char
	logic                  m_tlast;        // last_of_run

	// shadow of the configuration registers
	logic              dec_mode = 1'b0;
	logic [59:0]       sq_a = '0;
	logic [59:0]       sq_b = '0;
	logic [CODE_W-1:0] sq_last = '0;

	// pairing and word state
	logic [CODE_W-1:0] pair_first = '0;
	bit                pair_open = 1'b0;
	logic [CODE_W-1:0] word_last = '0;
	bit                word_open = 1'b0;

	out_item_t    step_out[$];
	out_item_t    due_chars[$];
	opening_row_t opening_rows[$];
	key_square_t  std_sq;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned chars_sent = 0;
	int unsigned chars_seen = 0;

	playfair_digraph_cipher_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [CODE_W-1:0] cell_at(int idx);
		if (idx < KEY_HALF_CELLS)
			return sq_a[idx*CODE_W +: CODE_W];
		if (idx < 2*KEY_HALF_CELLS)
			return sq_b[(idx-KEY_HALF_CELLS)*CODE_W +: CODE_W];
		return sq_last;
	endfunction

	// first match in row-major order, letters not in the square fall to cell 0
	function automatic int find_cell(logic [CODE_W-1:0] code);
		for (int i = 0; i < NUM_CELLS; i++)
			if (cell_at(i) == code)
				return i;
		return 0;
	endfunction

	function automatic void emit_char(logic [CHAR_W-1:0] ch);
		out_item_t item;
		item.ch = ch;
		item.last = 1'b0;
		if (step_out.size() < MAX_RESULTS)
			step_out.push_back(item);
	endfunction

	// in decrypt, plain letters come out lower case and x is dropped; encrypt output and odd codes stay upper case
	function automatic void emit_code(logic [CODE_W-1:0] code, bit dec);
		if (!dec || code >= NUM_LETTERS) begin
			emit_char(CH_UPPER_A + CHAR_W'(code));
		end else if (code != CODE_X) begin
			emit_char(CH_LOWER_A + CHAR_W'(code));
		end
	endfunction

	function automatic void cipher_pair(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b, bit dec);
		int pa, pb, r1, c1, r2, c2, shift, x, y;
		pa = find_cell(a);
		pb = find_cell(b);
		r1 = pa / SIDE;
		c1 = pa % SIDE;
		r2 = pb / SIDE;
		c2 = pb % SIDE;
		shift = dec ? SIDE - 1 : 1;
		if (r1 == r2) begin
			x = r1*SIDE + (c1 + shift) % SIDE;
			y = r2*SIDE + (c2 + shift) % SIDE;
		end else if (c1 == c2) begin
			x = ((r1 + shift) % SIDE)*SIDE + c1;
			y = ((r2 + shift) % SIDE)*SIDE + c2;
		end else begin
			x = r1*SIDE + c2;
			y = r2*SIDE + c1;
		end
		emit_code(cell_at(x), dec);
		emit_code(cell_at(y), dec);
	endfunction

	function automatic void feed_letter(logic [CODE_W-1:0] code, bit dec);
		if (pair_open) begin
			pair_open = 1'b0;
			cipher_pair(pair_first, code, dec);
		end else begin
			pair_first = code;
			pair_open = 1'b1;
		end
	endfunction

	// odd letter of a word gets an X partner
	function automatic void close_word();
		if (pair_open)
			feed_letter(CODE_X, 1'b0);
		word_open = 1'b0;
	endfunction

	// results caused by one accepted character, left in step_out
	function automatic void cipher_char_step(logic [CHAR_W-1:0] ch, bit fin);
		logic [CODE_W-1:0] code;
		bit is_letter;
		step_out.delete();
		is_letter = 1'b0;
		code = '0;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			code = CODE_W'(ch - CH_UPPER_A);
			is_letter = 1'b1;
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			code = CODE_W'(ch - CH_LOWER_A);
			is_letter = 1'b1;
		end
		if (!dec_mode) begin
			if (is_letter) begin
				if (code == CODE_J)
					code = CODE_I;
				if (word_open && word_last == code)
					feed_letter(CODE_X, 1'b0);
				feed_letter(code, 1'b0);
				word_last = code;
				word_open = 1'b1;
			end else if (ch == CH_SPACE) begin
				close_word();
				emit_char(CH_HASH);
			end
			if (fin)
				close_word();
		end else begin
			if (is_letter) begin
				feed_letter(code, 1'b1);
			end else if (ch == CH_HASH) begin
				pair_open = 1'b0;
				emit_char(CH_SPACE);
			end
		end
		if (fin) begin
			pair_open = 1'b0;
			word_open = 1'b0;
		end
		if (step_out.size() > 0)
			step_out[step_out.size()-1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------- helpers

	function automatic key_square_t square_of(string letters);
		key_square_t sq;
		for (int i = 0; i < NUM_CELLS; i++)
			sq[i] = CODE_W'(letters[i] - CH_UPPER_A);
		return sq;
	endfunction

	// 25 of the 26 letters in random order
	function automatic key_square_t shuffled_square();
		logic [CODE_W-1:0] pool [26];
		logic [CODE_W-1:0] t;
		key_square_t sq;
		int j;
		for (int i = 0; i < 26; i++)
			pool[i] = CODE_W'(i);
		for (int i = 25; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		for (int i = 0; i < NUM_CELLS; i++)
			sq[i] = pool[i];
		return sq;
	endfunction

	function automatic opening_row_t row_char(logic [CHAR_W-1:0] ch, bit fin);
		opening_row_t row;
		row = '0;
		row.ch = ch;
		row.fin = fin;
		return row;
	endfunction

	function automatic opening_row_t row_known(logic [CHAR_W-1:0] ch, bit fin,
			logic [2:0] n, logic [31:0] chars);
		opening_row_t row;
		row = row_char(ch, fin);
		row.typed = 1'b1;
		row.n_typed = n;
		row.typed_chars = chars;
		return row;
	endfunction

	function automatic opening_row_t row_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		opening_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	// ---------------------------------------------------------------- drivers

	// one config transfer, entered and left at a falling edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:     dec_mode = val[0];
			REG_KEY_A:    sq_a = val[59:0];
			REG_KEY_B:    sq_b = val[59:0];
			REG_KEY_LAST: sq_last = val[CODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_square(input key_square_t sq);
		write_reg(REG_KEY_A, CFG_DATA_W'(sq[11:0]));
		write_reg(REG_KEY_B, CFG_DATA_W'(sq[23:12]));
		write_reg(REG_KEY_LAST, CFG_DATA_W'(sq[24]));
	endtask

	// one character transfer; expectation either typed in or predicted
	task automatic send_char(input logic [CHAR_W-1:0] c, input bit fin, input bit typed,
			input logic [2:0] n_typed, input logic [31:0] typed_chars);
		out_item_t item;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		cipher_char_step(c, fin);
		if (typed) begin
			for (int k = 0; k < n_typed; k++) begin
				item.ch = typed_chars[8*(n_typed-1-k) +: 8];
				item.last = (k == n_typed - 1);
				due_chars.push_back(item);
			end
		end else begin
			foreach (step_out[k])
				due_chars.push_back(step_out[k]);
		end
		chars_sent++;
		@(negedge clk);
	endtask

	// hold the sender until all results are out and the block has settled
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (due_chars.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// words of random letters with doubled letters, separators, text ends and noise
	task automatic run_text(input int n_items, input bit drain_midway);
		int sent, len, r;
		logic [CHAR_W-1:0] ch, prev_ch;
		bit fin, drained;
		sent = 0;
		drained = 1'b0;
		prev_ch = CH_UPPER_A;
		fin = 1'b0;
		while (sent < n_items) begin
			len = $urandom_range(1, 7);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					ch = CHAR_W'($urandom_range(0, 255));
				end else if ($urandom_range(0, 5) == 0) begin
					ch = prev_ch ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
				end else begin
					ch = CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
					if ($urandom_range(0, 1))
						ch = ch + 8'h20;
				end
				prev_ch = ch;
				fin = (k == len - 1) && ($urandom_range(0, 7) == 0);
				send_char(ch, fin, 1'b0, '0, '0);
				sent++;
			end
			if (!fin) begin
				r = $urandom_range(0, 9);
				if (r < 6)
					ch = dec_mode ? CH_HASH : CH_SPACE;
				else if (r < 8)
					ch = dec_mode ? CH_SPACE : CH_HASH;
				else
					ch = CHAR_W'($urandom_range(0, 255));
				send_char(ch, $urandom_range(0, 4) == 0, 1'b0, '0, '0);
				sent++;
			end
			if (drain_midway && !drained && sent >= n_items / 2) begin
				wait_idle();
				drained = 1'b1;
			end
		end
	endtask

	// ---------------------------------------------------------------- receiver side

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_chars.size() == 0) begin
				$error("unexpected output transfer: out_char %h last_of_run %b",
					m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = due_chars.pop_front();
				chars_seen++;
				if (m_tdata !== want.ch) begin
					$error("out_char: expected %h, got %h", want.ch, m_tdata);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_run: expected %b, got %b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout with %0d results still due", due_chars.size());
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		opening_row_t row;
		key_square_t sq;
		std_sq = square_of("ABCDEFGHIKLMNOPQRSTUVWXYZ");

		// after reset every cell holds A, so every encrypted pair is AA
		opening_rows = '{
			row_known("a", 1'b0, 3'd0, 32'h0),
			row_known("B", 1'b0, 3'd2, "AA"),
			row_known(" ", 1'b0, 3'd1, "#"),
			row_known("z", 1'b1, 3'd2, "AA"),
			row_known("Q", 1'b0, 3'd0, 32'h0),
			row_known("q", 1'b1, 3'd4, "AAAA"),
			row_known(8'hFF, 1'b0, 3'd0, 32'h0),
			row_known(8'h00, 1'b1, 3'd0, 32'h0),
			row_known("J", 1'b0, 3'd0, 32'h0),
			row_known(" ", 1'b1, 3'd3, "AA#"),
			row_reg(REG_KEY_A, CFG_DATA_W'(std_sq[11:0])),
			row_reg(REG_KEY_B, CFG_DATA_W'(std_sq[23:12])),
			row_reg(REG_KEY_LAST, CFG_DATA_W'(std_sq[24])),
			// same row with wrap, same column with wrap, rectangle, doubled letter
			row_char("E", 1'b0), row_char("a", 1'b0),
			row_char("A", 1'b0), row_char("V", 1'b0),
			row_char("H", 1'b0), row_char("z", 1'b0),
			row_char("L", 1'b0), row_char("l", 1'b0),
			row_char(" ", 1'b0),
			row_reg(REG_MODE, CFG_DATA_W'(1)),
			// odd letter dropped by separator, x dropped, J missing from square
			row_char("Q", 1'b0), row_char("#", 1'b0),
			row_char("Y", 1'b0), row_char("w", 1'b0),
			row_char("J", 1'b0), row_char("e", 1'b0),
			row_char("M", 1'b0), row_char("%", 1'b1)
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i]) begin
			row = opening_rows[i];
			if (row.is_reg) begin
				wait_idle();
				write_reg(row.idx, row.data);
			end else begin
				send_char(row.ch, row.fin, row.typed, row.n_typed, row.typed_chars);
			end
		end

		// random text under a new key square and flow-control mix per phase
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_reg(REG_MODE, CFG_DATA_W'(0));
					load_square(shuffled_square());
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
					write_reg(REG_MODE, CFG_DATA_W'(1));
					load_square(shuffled_square());
				end
				2: begin
					// raw codes: duplicates and codes past Z
					send_idle_pct = 0;
					recv_stall_pct = 58;
					write_reg(REG_MODE, CFG_DATA_W'(0));
					write_reg(REG_KEY_A, CFG_DATA_W'({$urandom, $urandom}));
					write_reg(REG_KEY_B, CFG_DATA_W'({$urandom, $urandom}));
					write_reg(REG_KEY_LAST, CFG_DATA_W'($urandom_range(0, 25)));
				end
				3: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
					write_reg(REG_MODE, CFG_DATA_W'(1));
					write_reg(REG_KEY_A, {CFG_DATA_W{1'b1}});
					write_reg(REG_KEY_B, {CFG_DATA_W{1'b1}});
					write_reg(REG_KEY_LAST, CFG_DATA_W'(25));
				end
				4: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_reg(REG_MODE, CFG_DATA_W'(0));
					write_reg(REG_KEY_A, '0);
					write_reg(REG_KEY_B, '0);
					write_reg(REG_KEY_LAST, '0);
				end
				default: begin
					send_idle_pct = 58;
					recv_stall_pct = 58;
					write_reg(REG_MODE, CFG_DATA_W'(1));
					sq = std_sq;
					load_square(sq);
				end
			endcase
			run_text(PHASE_CHARS, p == 2);
		end

		wait_idle();
		$display("sent %0d characters, checked %0d output characters in %0d cycles",
			chars_sent, chars_seen, cycle_count);
		$display("both modes; standard, shuffled, raw, all-zero and all-one squares; idle mixes");
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
